// ===== design/heat_cool_thermostat_controller_defines.svh =====
// Assertion macros shared by the thermostat controller checker.
`ifndef HEAT_COOL_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define HEAT_COOL_THERMOSTAT_CONTROLLER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define HCTC_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// A condition that, once seen, requires another one on the next clock edge.
`define HCTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hctc_pkg.sv =====
// Shared types, codes and helpers of the heating/cooling thermostat controller.
package hctc_pkg;

  localparam int TEMP_W = 16;
  localparam int BAND_W = 12;
  localparam int AGE_W  = 16;
  localparam int CMP_W  = 18;
  localparam int OP_W   = 2;
  localparam int SIDX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W = 2;
  localparam int RELAY_W = 2;
  localparam int SEL_W  = 5;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE  = 3'd5;

  // Comfort modes.
  localparam logic [MODE_W-1:0] MODE_BEDROOM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AWAY    = 2'd2;

  // Relay states; the remembered direction uses the same codes.
  localparam logic [RELAY_W-1:0] RELAY_OFF  = 2'd0;
  localparam logic [RELAY_W-1:0] RELAY_HEAT = 2'd1;
  localparam logic [RELAY_W-1:0] RELAY_COOL = 2'd2;

  // Register reset values.
  localparam logic [TEMP_W-1:0] TARGET_RST = 16'd5376;
  localparam logic [BAND_W-1:0] INNER_RST  = 12'd128;
  localparam logic [BAND_W-1:0] OUTER_RST  = 12'd512;
  localparam logic [AGE_W-1:0]  STALE_RST  = 16'd600;

  typedef struct packed {
    logic upd;
    logic tick;
    logic walk_clear;
    logic walk_step;
    logic check;
    logic div_step;
    logic decide;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
    logic no_avg;
    logic div_last;
  } stat_t;

  function automatic logic signed [CMP_W-1:0] sx_temp(input logic [TEMP_W-1:0] v);
    return $signed({{(CMP_W-TEMP_W){v[TEMP_W-1]}}, v});
  endfunction

  function automatic logic signed [CMP_W-1:0] zx_band(input logic [BAND_W-1:0] v);
    return $signed({{(CMP_W-BAND_W){1'b0}}, v});
  endfunction

endpackage

// ===== design/hctc_ctrl.sv =====
// Sequencing state machine of the thermostat controller.
module hctc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hctc_pkg::OP_W-1:0]  opcode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hctc_pkg::cmd_t             cmd,
  input  hctc_pkg::stat_t            stat
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            hctc_pkg::OP_UPDATE: begin
              cmd.upd = 1'b1;
              state_next = ST_DONE;
            end
            hctc_pkg::OP_TICK: begin
              cmd.tick = 1'b1;
              state_next = ST_DONE;
            end
            hctc_pkg::OP_EVAL: begin
              cmd.walk_clear = 1'b1;
              state_next = ST_WALK;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_next = stat.no_avg ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/hctc_datapath.sv =====
// Sensor store, statistics walk, serial divider and relay logic.
module hctc_datapath #(
  parameter int NUM_SENSORS    = 8,
  parameter int OUTSIDE_SENSOR = 7,
  parameter int BEDROOM_SENSOR = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hctc_pkg::cmd_t                     cmd,
  output hctc_pkg::stat_t                    stat,
  input  logic [hctc_pkg::SIDX_W-1:0]        sensor_index,
  input  logic signed [hctc_pkg::TEMP_W-1:0] temperature,
  input  logic                               cfg_we,
  input  logic [hctc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hctc_pkg::TEMP_W-1:0]        cfg_wdata,
  output logic [hctc_pkg::RELAY_W-1:0]       relay_state,
  output logic signed [hctc_pkg::TEMP_W-1:0] avg_temp,
  output logic signed [hctc_pkg::TEMP_W-1:0] min_temp,
  output logic signed [hctc_pkg::TEMP_W-1:0] max_temp,
  output logic                               reading_valid
);

  localparam int TW     = hctc_pkg::TEMP_W;
  localparam int IDX_W  = $clog2(NUM_SENSORS);
  localparam int WSUM_W = $clog2(NUM_SENSORS + 1);
  localparam int SUM_W  = TW + WSUM_W;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int OUT_IDX = OUTSIDE_SENSOR % NUM_SENSORS;
  localparam bit OUT_PRESENT = (OUTSIDE_SENSOR < NUM_SENSORS);
  localparam logic [IDX_W-1:0] OUT_SEL = IDX_W'(OUT_IDX);

  // Configuration registers.
  logic signed [TW-1:0]                 target_temp;
  logic                                 system_enable;
  logic [hctc_pkg::MODE_W-1:0]          comfort_mode;
  logic [hctc_pkg::BAND_W-1:0]          inner_band;
  logic [hctc_pkg::BAND_W-1:0]          outer_band;
  logic [hctc_pkg::AGE_W-1:0]           stale_limit;

  // Sensor store.
  logic signed [TW-1:0]                 sensor_reading [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]               sensor_valid;
  logic [hctc_pkg::AGE_W-1:0]           sensor_age [NUM_SENSORS];
  logic [hctc_pkg::AGE_W-1:0]           age_inc [NUM_SENSORS];
  logic [IDX_W-1:0]                     upd_idx;
  logic                                 upd_in_range;

  // Walk accumulators.
  logic [IDX_W-1:0]                     walk_idx;
  logic                                 walk_any;
  logic signed [TW-1:0]                 walk_lo;
  logic signed [TW-1:0]                 walk_hi;
  logic signed [SUM_W-1:0]              walk_sum;
  logic [WSUM_W-1:0]                    walk_wsum;
  logic signed [TW-1:0]                 walk_rd;
  logic                                 walk_vd;
  logic                                 bed_hit;
  logic                                 walk_w;

  // Divider.
  logic [SUM_W-1:0]                     abs_sum;
  logic [SUM_W-1:0]                     div_q;
  logic [WSUM_W-1:0]                    div_rem;
  logic [WSUM_W:0]                      rem_sh;
  logic                                 div_ge;
  logic [CNT_W-1:0]                     div_cnt;
  logic                                 div_neg;
  logic signed [TW-1:0]                 avg_new;

  // Relay machine and evaluation registers.
  logic [hctc_pkg::RELAY_W-1:0]         relay_mode;
  logic [hctc_pkg::RELAY_W-1:0]         last_direction;
  logic signed [TW-1:0]                 average_reg;
  logic signed [TW-1:0]                 min_reg;
  logic signed [TW-1:0]                 max_reg;
  logic                                 eval_ok;
  logic signed [hctc_pkg::CMP_W-1:0]    avg_c;
  logic signed [hctc_pkg::CMP_W-1:0]    lo_c;
  logic signed [hctc_pkg::CMP_W-1:0]    hi_c;
  logic signed [hctc_pkg::CMP_W-1:0]    tgt_c;
  logic signed [hctc_pkg::CMP_W-1:0]    tgt_lo_in;
  logic signed [hctc_pkg::CMP_W-1:0]    tgt_hi_in;
  logic signed [hctc_pkg::CMP_W-1:0]    tgt_lo_out;
  logic signed [hctc_pkg::CMP_W-1:0]    tgt_hi_out;
  logic                                 heating;
  logic [hctc_pkg::RELAY_W-1:0]         decide_next;
  logic [hctc_pkg::RELAY_W-1:0]         relay_target;
  logic                                 relay_we;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp   <= hctc_pkg::TARGET_RST;
      system_enable <= 1'b0;
      comfort_mode  <= '0;
      inner_band    <= hctc_pkg::INNER_RST;
      outer_band    <= hctc_pkg::OUTER_RST;
      stale_limit   <= hctc_pkg::STALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hctc_pkg::CFG_TARGET: target_temp   <= cfg_wdata;
        hctc_pkg::CFG_ENABLE: system_enable <= cfg_wdata[0];
        hctc_pkg::CFG_MODE:   comfort_mode  <= cfg_wdata[hctc_pkg::MODE_W-1:0];
        hctc_pkg::CFG_INNER:  inner_band    <= cfg_wdata[hctc_pkg::BAND_W-1:0];
        hctc_pkg::CFG_OUTER:  outer_band    <= cfg_wdata[hctc_pkg::BAND_W-1:0];
        hctc_pkg::CFG_STALE:  stale_limit   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sensor updates and ageing.
  assign upd_idx = IDX_W'(sensor_index);
  assign upd_in_range = hctc_pkg::SEL_W'(sensor_index) < hctc_pkg::SEL_W'(NUM_SENSORS);

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      age_inc[i] = (sensor_age[i] != hctc_pkg::AGE_MAX) ?
                   sensor_age[i] + 1'b1 : sensor_age[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && upd_in_range) begin
      sensor_reading[upd_idx] <= temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_valid <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        sensor_age[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (cmd.upd && upd_in_range && (upd_idx == IDX_W'(i))) begin
          sensor_valid[i] <= 1'b1;
          sensor_age[i] <= '0;
        end else if (cmd.tick) begin
          sensor_age[i] <= age_inc[i];
          if (age_inc[i] > stale_limit) begin
            sensor_valid[i] <= 1'b0;
          end
        end
      end
    end
  end

  // Walk: one sensor per cycle into min, max, weighted sum and weight count.
  assign walk_rd = sensor_reading[walk_idx];
  assign walk_vd = sensor_valid[walk_idx];
  assign bed_hit = hctc_pkg::SEL_W'(walk_idx) == hctc_pkg::SEL_W'(BEDROOM_SENSOR);

  always_comb begin
    case (comfort_mode)
      hctc_pkg::MODE_BEDROOM: walk_w = bed_hit;
      hctc_pkg::MODE_AWAY:    walk_w = !bed_hit;
      default:                walk_w = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_clear) begin
      walk_idx  <= '0;
      walk_any  <= 1'b0;
      walk_sum  <= '0;
      walk_wsum <= '0;
    end else if (cmd.walk_step) begin
      walk_idx <= walk_idx + 1'b1;
      if (walk_vd) begin
        if (!walk_any || walk_rd > walk_hi) begin
          walk_hi <= walk_rd;
        end
        if (!walk_any || walk_rd < walk_lo) begin
          walk_lo <= walk_rd;
        end
        walk_any <= 1'b1;
        if (walk_w) begin
          walk_sum  <= walk_sum + {{(SUM_W-TW){walk_rd[TW-1]}}, walk_rd};
          walk_wsum <= walk_wsum + 1'b1;
        end
      end
    end
  end

  assign stat.walk_last = (walk_idx == IDX_W'(NUM_SENSORS - 1));
  assign stat.no_avg    = !walk_any || (walk_wsum == '0);

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign abs_sum = walk_sum[SUM_W-1] ? SUM_W'(-walk_sum) : SUM_W'(walk_sum);
  assign rem_sh  = {div_rem, div_q[SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, walk_wsum};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      div_q   <= abs_sum;
      div_rem <= '0;
      div_cnt <= '0;
      div_neg <= walk_sum[SUM_W-1];
    end else if (cmd.div_step) begin
      div_q   <= {div_q[SUM_W-2:0], div_ge};
      div_rem <= div_ge ? WSUM_W'(rem_sh - {1'b0, walk_wsum}) : rem_sh[WSUM_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign stat.div_last = (div_cnt == CNT_W'(SUM_W - 1));

  // Truncation toward zero: negate the magnitude quotient for a negative sum.
  assign avg_new = div_neg ? -$signed(div_q[TW-1:0]) : $signed(div_q[TW-1:0]);

  assign avg_c      = hctc_pkg::sx_temp(avg_new);
  assign lo_c       = hctc_pkg::sx_temp(min_reg);
  assign hi_c       = hctc_pkg::sx_temp(max_reg);
  assign tgt_c      = hctc_pkg::sx_temp(target_temp);
  assign tgt_lo_in  = tgt_c - hctc_pkg::zx_band(inner_band);
  assign tgt_hi_in  = tgt_c + hctc_pkg::zx_band(inner_band);
  assign tgt_lo_out = tgt_c - hctc_pkg::zx_band(outer_band);
  assign tgt_hi_out = tgt_c + hctc_pkg::zx_band(outer_band);

  always_comb begin
    if (OUT_PRESENT && sensor_valid[OUT_SEL]) begin
      heating = sensor_reading[OUT_SEL] < target_temp;
    end else if (last_direction == hctc_pkg::RELAY_OFF) begin
      heating = avg_c < tgt_c;
    end else begin
      heating = (last_direction == hctc_pkg::RELAY_HEAT);
    end
  end

  always_comb begin
    decide_next = relay_mode;
    if (!system_enable) begin
      decide_next = hctc_pkg::RELAY_OFF;
    end else begin
      case (relay_mode)
        hctc_pkg::RELAY_HEAT: begin
          if (avg_c >= tgt_c || hi_c >= tgt_hi_out) begin
            decide_next = hctc_pkg::RELAY_OFF;
          end
        end
        hctc_pkg::RELAY_COOL: begin
          if (avg_c <= tgt_c || lo_c < tgt_lo_out) begin
            decide_next = hctc_pkg::RELAY_OFF;
          end
        end
        default: begin
          if (heating) begin
            if (avg_c < tgt_lo_in && hi_c < tgt_hi_out) begin
              decide_next = hctc_pkg::RELAY_HEAT;
            end
          end else if (avg_c > tgt_hi_in && lo_c > tgt_lo_out) begin
            decide_next = hctc_pkg::RELAY_COOL;
          end
        end
      endcase
    end
  end

  // A failed evaluation forces the relays off at the check step.
  assign relay_we     = cmd.decide || (cmd.check && stat.no_avg);
  assign relay_target = cmd.decide ? decide_next : hctc_pkg::RELAY_OFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_mode     <= hctc_pkg::RELAY_OFF;
      last_direction <= hctc_pkg::RELAY_OFF;
    end else if (cfg_we && cfg_index == hctc_pkg::CFG_ENABLE) begin
      last_direction <= hctc_pkg::RELAY_OFF;
    end else if (relay_we && relay_target != relay_mode) begin
      if (relay_mode != hctc_pkg::RELAY_OFF) begin
        last_direction <= relay_mode;
      end
      relay_mode <= relay_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_reg <= '0;
      min_reg     <= '0;
      max_reg     <= '0;
      eval_ok     <= 1'b0;
    end else begin
      if (cmd.check) begin
        if (walk_any) begin
          min_reg <= walk_lo;
          max_reg <= walk_hi;
        end
        if (stat.no_avg) begin
          eval_ok <= 1'b0;
        end
      end
      if (cmd.decide) begin
        average_reg <= avg_new;
        eval_ok     <= 1'b1;
      end
    end
  end

  // Output register: one result per transaction.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      relay_state   <= relay_mode;
      avg_temp      <= average_reg;
      min_temp      <= min_reg;
      max_temp      <= max_reg;
      reading_valid <= eval_ok;
    end
  end

endmodule

// ===== design/heat_cool_thermostat_controller.sv =====
// Top level of the heating/cooling thermostat controller.
//
//   channel  | dir | payload                                    | transaction when
//   ---------+-----+--------------------------------------------+------------------------
//   in       | in  | opcode, sensor_index, temperature          | in_valid & !in_stall
//   out      | out | relay_state, avg_temp, min_temp, max_temp, | out_valid & !out_stall
//            |     | reading_valid                              |
//   cfg      | in  | cfg_index, cfg_wdata                       | cfg_we
//
// A sensor update, a tick or an unused opcode passes from the idle state through the done
// state into the output register. An evaluation runs the one-sensor-per-cycle statistics
// walk, a check step, the one-bit-per-cycle divider on the SUM_W-bit sum, where SUM_W is
// 16 plus the bits of the weight count, and a decide step. A failed evaluation skips the
// divider. Reset is synchronous, restores the configuration defaults and clears sensor
// validity, ages and the relay state. While a result is stalled the next transaction is
// still taken; its result waits until the output register is free.
module heat_cool_thermostat_controller #(
  parameter int NUM_SENSORS    = 8,
  parameter int OUTSIDE_SENSOR = 7,
  parameter int BEDROOM_SENSOR = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hctc_pkg::OP_W-1:0]          opcode,
  input  logic [hctc_pkg::SIDX_W-1:0]        sensor_index,
  input  logic signed [hctc_pkg::TEMP_W-1:0] temperature,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hctc_pkg::RELAY_W-1:0]       relay_state,
  output logic signed [hctc_pkg::TEMP_W-1:0] avg_temp,
  output logic signed [hctc_pkg::TEMP_W-1:0] min_temp,
  output logic signed [hctc_pkg::TEMP_W-1:0] max_temp,
  output logic                               reading_valid,
  input  logic                               cfg_we,
  input  logic [hctc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hctc_pkg::TEMP_W-1:0]        cfg_wdata
);

  hctc_pkg::cmd_t  cmd;
  hctc_pkg::stat_t stat;

  hctc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  hctc_datapath #(
    .NUM_SENSORS    (NUM_SENSORS),
    .OUTSIDE_SENSOR (OUTSIDE_SENSOR),
    .BEDROOM_SENSOR (BEDROOM_SENSOR)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sensor_index  (sensor_index),
    .temperature   (temperature),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .relay_state   (relay_state),
    .avg_temp      (avg_temp),
    .min_temp      (min_temp),
    .max_temp      (max_temp),
    .reading_valid (reading_valid)
  );

endmodule

// ===== design/hctc_checker.sv =====
// Port-level checker of the thermostat controller and its bind.
`include "heat_cool_thermostat_controller_defines.svh"

module hctc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [hctc_pkg::RELAY_W-1:0]       relay_state,
  input logic signed [hctc_pkg::TEMP_W-1:0] avg_temp,
  input logic signed [hctc_pkg::TEMP_W-1:0] min_temp,
  input logic signed [hctc_pkg::TEMP_W-1:0] max_temp,
  input logic                               reading_valid
);

  // Only the three relay codes ever reach the output.
  `HCTC_ASSERT_HOLDS(a_relay_code, !out_valid || relay_state == hctc_pkg::RELAY_OFF || relay_state == hctc_pkg::RELAY_HEAT || relay_state == hctc_pkg::RELAY_COOL, "relay_state carries an unused code")

  // A relay can only be on after a successful evaluation.
  `HCTC_ASSERT_HOLDS(a_relay_needs_eval, !(out_valid && relay_state != hctc_pkg::RELAY_OFF) || reading_valid, "relay on without a valid evaluation")

  // A weighted average of valid readings lies between their minimum and maximum.
  `HCTC_ASSERT_HOLDS(a_avg_in_range, !(out_valid && reading_valid) || (min_temp <= avg_temp && avg_temp <= max_temp), "average outside the min/max range")

  // A stalled result is held unchanged.
  `HCTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(relay_state) && $stable(avg_temp) && $stable(reading_valid), "stalled result changed")

endmodule

bind heat_cool_thermostat_controller hctc_checker u_hctc_checker (.*);

// ===== tb/heat_cool_thermostat_controller_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the heating/cooling thermostat controller.
module heat_cool_thermostat_controller_tb;

  localparam int NSENS        = 8;
  localparam logic [hctc_pkg::SIDX_W-1:0] OUT_SLOT = 3'd7;
  localparam logic [hctc_pkg::SIDX_W-1:0] BED_SLOT = 3'd0;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASES       = 8;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam logic [hctc_pkg::OP_W-1:0]      OP_SPARE   = 2'd3;
  localparam logic [hctc_pkg::MODE_W-1:0]    MODE_ALL   = 2'd0;
  localparam logic [hctc_pkg::MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [hctc_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [hctc_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [hctc_pkg::RELAY_W-1:0]       relay;
    logic signed [hctc_pkg::TEMP_W-1:0] avg;
    logic signed [hctc_pkg::TEMP_W-1:0] lo;
    logic signed [hctc_pkg::TEMP_W-1:0] hi;
    logic                               ok;
  } thermo_report_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [hctc_pkg::OP_W-1:0]          opcode = hctc_pkg::OP_UPDATE;
  logic [hctc_pkg::SIDX_W-1:0]        sensor_index = '0;
  logic signed [hctc_pkg::TEMP_W-1:0] temperature = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [hctc_pkg::RELAY_W-1:0]       relay_state;
  logic signed [hctc_pkg::TEMP_W-1:0] avg_temp;
  logic signed [hctc_pkg::TEMP_W-1:0] min_temp;
  logic signed [hctc_pkg::TEMP_W-1:0] max_temp;
  logic                               reading_valid;
  logic                               cfg_we = 1'b0;
  logic [hctc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [hctc_pkg::TEMP_W-1:0]        cfg_wdata = '0;

  heat_cool_thermostat_controller dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .sensor_index (sensor_index),
    .temperature  (temperature),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .relay_state  (relay_state),
    .avg_temp     (avg_temp),
    .min_temp     (min_temp),
    .max_temp     (max_temp),
    .reading_valid(reading_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  thermo_report_t pending_reports[$];
  int             errors = 0;
  int             cycle_count = 0;
  bit             idle_on = 1'b1;
  bit             long_hold_req = 1'b0;

  // Shadow of the configuration and of the controller state.
  logic signed [hctc_pkg::TEMP_W-1:0] target_m;
  logic                               enable_m;
  logic [hctc_pkg::MODE_W-1:0]        mode_m;
  logic [hctc_pkg::BAND_W-1:0]        inner_m;
  logic [hctc_pkg::BAND_W-1:0]        outer_m;
  logic [hctc_pkg::AGE_W-1:0]         stale_m;
  logic signed [hctc_pkg::TEMP_W-1:0] reading_m [NSENS];
  bit                                 fresh_m [NSENS];
  logic [hctc_pkg::AGE_W-1:0]         age_m [NSENS];
  logic [hctc_pkg::RELAY_W-1:0]       relay_m;
  logic [hctc_pkg::RELAY_W-1:0]       last_dir_m;
  logic signed [hctc_pkg::TEMP_W-1:0] avg_m;
  logic signed [hctc_pkg::TEMP_W-1:0] min_m;
  logic signed [hctc_pkg::TEMP_W-1:0] max_m;
  bit                                 stats_ok_m;

  function automatic logic [hctc_pkg::SIDX_W-1:0] rnd_idx();
    return hctc_pkg::SIDX_W'($urandom);
  endfunction

  function automatic logic signed [hctc_pkg::TEMP_W-1:0] rnd_temp();
    return hctc_pkg::TEMP_W'($urandom);
  endfunction

  function automatic void reset_shadow();
    target_m = hctc_pkg::TARGET_RST;
    enable_m = 1'b0;
    mode_m = MODE_ALL;
    inner_m = hctc_pkg::INNER_RST;
    outer_m = hctc_pkg::OUTER_RST;
    stale_m = hctc_pkg::STALE_RST;
    for (int i = 0; i < NSENS; i++) begin
      reading_m[i] = '0;
      fresh_m[i] = 1'b0;
      age_m[i] = '0;
    end
    relay_m = hctc_pkg::RELAY_OFF;
    last_dir_m = hctc_pkg::RELAY_OFF;
    avg_m = '0;
    min_m = '0;
    max_m = '0;
    stats_ok_m = 1'b0;
  endfunction

  function automatic void shadow_cfg(logic [hctc_pkg::CFG_IDX_W-1:0] idx,
                                     logic [hctc_pkg::TEMP_W-1:0] d);
    case (idx)
      hctc_pkg::CFG_TARGET: target_m = d;
      hctc_pkg::CFG_ENABLE: begin
        enable_m = d[0];
        last_dir_m = hctc_pkg::RELAY_OFF;
      end
      hctc_pkg::CFG_MODE:  mode_m = d[hctc_pkg::MODE_W-1:0];
      hctc_pkg::CFG_INNER: inner_m = d[hctc_pkg::BAND_W-1:0];
      hctc_pkg::CFG_OUTER: outer_m = d[hctc_pkg::BAND_W-1:0];
      hctc_pkg::CFG_STALE: stale_m = d;
      default: ;
    endcase
  endfunction

  // Leaving heating or cooling remembers that direction.
  function automatic void move_relay(logic [hctc_pkg::RELAY_W-1:0] nxt);
    if (relay_m != nxt) begin
      if (relay_m == hctc_pkg::RELAY_HEAT || relay_m == hctc_pkg::RELAY_COOL) begin
        last_dir_m = relay_m;
      end
      relay_m = nxt;
    end
  endfunction

  function automatic void evaluate_sensors();
    int lo, hi, sum, wsum, avg, w, t, tgt, inner, outer;
    bit any, heat;
    lo = 0;
    hi = 0;
    sum = 0;
    wsum = 0;
    any = 1'b0;
    tgt = int'(target_m);
    inner = int'(inner_m);
    outer = int'(outer_m);
    for (int i = 0; i < NSENS; i++) begin
      if (fresh_m[i]) begin
        t = int'(reading_m[i]);
        if (!any || t > hi) hi = t;
        if (!any || t < lo) lo = t;
        any = 1'b1;
        case (mode_m)
          hctc_pkg::MODE_BEDROOM: w = (i == BED_SLOT) ? 1 : 0;
          hctc_pkg::MODE_AWAY:    w = (i == BED_SLOT) ? 0 : 1;
          default:                w = 1;
        endcase
        sum += t * w;
        wsum += w;
      end
    end
    if (!any) begin
      stats_ok_m = 1'b0;
      move_relay(hctc_pkg::RELAY_OFF);
      return;
    end
    min_m = lo[hctc_pkg::TEMP_W-1:0];
    max_m = hi[hctc_pkg::TEMP_W-1:0];
    if (wsum == 0) begin
      stats_ok_m = 1'b0;
      move_relay(hctc_pkg::RELAY_OFF);
      return;
    end
    avg = sum / wsum;
    avg_m = avg[hctc_pkg::TEMP_W-1:0];
    stats_ok_m = 1'b1;
    if (!enable_m) begin
      move_relay(hctc_pkg::RELAY_OFF);
      return;
    end
    case (relay_m)
      hctc_pkg::RELAY_HEAT: begin
        if (avg >= tgt || hi >= tgt + outer) move_relay(hctc_pkg::RELAY_OFF);
      end
      hctc_pkg::RELAY_COOL: begin
        if (avg <= tgt || lo < tgt - outer) move_relay(hctc_pkg::RELAY_OFF);
      end
      default: begin
        if (fresh_m[OUT_SLOT]) heat = (int'(reading_m[OUT_SLOT]) < tgt);
        else if (last_dir_m == hctc_pkg::RELAY_OFF) heat = (avg < tgt);
        else heat = (last_dir_m == hctc_pkg::RELAY_HEAT);
        if (heat) begin
          if (avg < tgt - inner && hi < tgt + outer) move_relay(hctc_pkg::RELAY_HEAT);
        end else if (avg > tgt + inner && lo > tgt - outer) begin
          move_relay(hctc_pkg::RELAY_COOL);
        end
      end
    endcase
  endfunction

  function automatic thermo_report_t predict_thermostat(
      logic [hctc_pkg::OP_W-1:0] op, logic [hctc_pkg::SIDX_W-1:0] idx,
      logic signed [hctc_pkg::TEMP_W-1:0] t);
    thermo_report_t r;
    case (op)
      hctc_pkg::OP_UPDATE: begin
        reading_m[idx] = t;
        fresh_m[idx] = 1'b1;
        age_m[idx] = '0;
      end
      hctc_pkg::OP_TICK: begin
        for (int i = 0; i < NSENS; i++) begin
          if (age_m[i] != hctc_pkg::AGE_MAX) age_m[i] = age_m[i] + 1'b1;
          if (age_m[i] > stale_m) fresh_m[i] = 1'b0;
        end
      end
      hctc_pkg::OP_EVAL: evaluate_sensors();
      default: ;
    endcase
    r.relay = relay_m;
    r.avg = avg_m;
    r.lo = min_m;
    r.hi = max_m;
    r.ok = stats_ok_m;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(logic [hctc_pkg::OP_W-1:0] op, logic [hctc_pkg::SIDX_W-1:0] idx,
                           logic signed [hctc_pkg::TEMP_W-1:0] t);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    sensor_index <= idx;
    temperature <= t;
    do @(posedge clk); while (in_stall);
    pending_reports.push_back(predict_thermostat(op, idx, t));
  endtask

  task automatic send_eval();
    send_item(hctc_pkg::OP_EVAL, '0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Every item yields a report, so an empty queue means the block is idle.
  task automatic write_reg(logic [hctc_pkg::CFG_IDX_W-1:0] idx,
                           logic [hctc_pkg::TEMP_W-1:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    shadow_cfg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void compare_field(string name,
                                        logic signed [hctc_pkg::TEMP_W-1:0] want,
                                        logic signed [hctc_pkg::TEMP_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_reports
    thermo_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual relay %0d avg %0d",
                 $time, relay_state, avg_temp);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("relay_state", hctc_pkg::TEMP_W'(want.relay),
                      hctc_pkg::TEMP_W'(relay_state));
        compare_field("avg_temp", want.avg, avg_temp);
        compare_field("min_temp", want.lo, min_temp);
        compare_field("max_temp", want.hi, max_temp);
        compare_field("reading_valid", hctc_pkg::TEMP_W'(want.ok),
                      hctc_pkg::TEMP_W'(reading_valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("heat_cool_thermostat_controller verification failed");
      $finish;
    end
  end

  // Result side: a random stall before each transaction, or one long hold on request.
  initial begin : report_sink
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = idle_on ? $urandom_range(0, 5) : 0;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_reset_state();
    send_item(hctc_pkg::OP_EVAL, rnd_idx(), rnd_temp());
    send_item(hctc_pkg::OP_TICK, rnd_idx(), rnd_temp());
    send_item(OP_SPARE, rnd_idx(), rnd_temp());
  endtask

  task automatic test_heating_cycle();
    write_reg(hctc_pkg::CFG_ENABLE, 16'd1);
    send_item(hctc_pkg::OP_UPDATE, OUT_SLOT, 16'sd1000);
    send_item(hctc_pkg::OP_UPDATE, 3'd3, 16'sd5000);
    send_eval();
    // The hottest sensor crossing the outer band ends heating.
    send_item(hctc_pkg::OP_UPDATE, 3'd3, 16'sd6000);
    send_eval();
  endtask

  task automatic test_cooling_cycle();
    send_item(hctc_pkg::OP_UPDATE, OUT_SLOT, 16'sd9000);
    send_item(hctc_pkg::OP_UPDATE, 3'd3, 16'sd5700);
    send_eval();
    send_item(hctc_pkg::OP_UPDATE, 3'd3, 16'sd4000);
    send_eval();
  endtask

  // Without a valid outside reading the last direction, then the average, decides.
  task automatic test_direction_memory();
    write_reg(hctc_pkg::CFG_STALE, 16'd1);
    send_item(hctc_pkg::OP_TICK, '0, '0);
    send_item(hctc_pkg::OP_TICK, '0, '0);
    send_eval();
    write_reg(hctc_pkg::CFG_STALE, hctc_pkg::STALE_RST);
    send_item(hctc_pkg::OP_UPDATE, BED_SLOT, 16'sd6000);
    send_eval();
    write_reg(hctc_pkg::CFG_ENABLE, 16'd1);
    send_item(hctc_pkg::OP_UPDATE, BED_SLOT, 16'sd4000);
    send_eval();
  endtask

  task automatic test_comfort_modes();
    send_item(hctc_pkg::OP_UPDATE, 3'd4, 16'sd5000);
    write_reg(hctc_pkg::CFG_MODE, hctc_pkg::TEMP_W'(hctc_pkg::MODE_BEDROOM));
    send_eval();
    write_reg(hctc_pkg::CFG_MODE, hctc_pkg::TEMP_W'(MODE_SPARE));
    send_eval();
    // Only the bedroom valid while it carries no weight: the weight sum is zero.
    write_reg(hctc_pkg::CFG_MODE, hctc_pkg::TEMP_W'(hctc_pkg::MODE_AWAY));
    write_reg(hctc_pkg::CFG_STALE, 16'd0);
    send_item(hctc_pkg::OP_TICK, '0, '0);
    send_item(hctc_pkg::OP_UPDATE, BED_SLOT, 16'sd5500);
    send_eval();
    write_reg(hctc_pkg::CFG_MODE, hctc_pkg::TEMP_W'(MODE_ALL));
    write_reg(hctc_pkg::CFG_STALE, hctc_pkg::STALE_RST);
  endtask

  task automatic test_extremes_and_disable();
    write_reg(hctc_pkg::CFG_TARGET, 16'h8000);
    write_reg(hctc_pkg::CFG_INNER, 16'h0FFF);
    write_reg(hctc_pkg::CFG_OUTER, 16'h0FFF);
    send_item(hctc_pkg::OP_UPDATE, 3'd1, 16'sh7FFF);
    send_item(hctc_pkg::OP_UPDATE, 3'd6, 16'sh8000);
    send_eval();
    // Two small negative readings; the valid bedroom reading keeps the average positive.
    send_item(hctc_pkg::OP_UPDATE, 3'd1, -16'sd1);
    send_item(hctc_pkg::OP_UPDATE, 3'd6, -16'sd2);
    send_eval();
    write_reg(hctc_pkg::CFG_ENABLE, 16'd0);
    write_reg(hctc_pkg::CFG_TARGET, 16'h7FFF);
    write_reg(hctc_pkg::CFG_INNER, 16'd0);
    write_reg(hctc_pkg::CFG_OUTER, 16'd0);
    send_eval();
  endtask

  // A reading stays valid while its age equals the limit and goes stale one tick later.
  task automatic test_stale_boundary();
    idle_on = 1'b0;
    write_reg(hctc_pkg::CFG_STALE, 16'd3);
    send_item(hctc_pkg::OP_UPDATE, 3'd2, 16'sd5376);
    repeat (3) send_item(hctc_pkg::OP_TICK, rnd_idx(), rnd_temp());
    send_eval();
    send_item(hctc_pkg::OP_TICK, rnd_idx(), rnd_temp());
    send_eval();
    write_reg(hctc_pkg::CFG_STALE, hctc_pkg::STALE_RST);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    drain();
    long_hold_req = 1'b1;
    for (int i = 0; i < 14; i++) begin
      if (i % 3 == 2) send_eval();
      else send_item(hctc_pkg::OP_UPDATE, rnd_idx(),
                     hctc_pkg::TEMP_W'(5376 + $urandom_range(0, 1200) - 600));
    end
  endtask

  task automatic test_random_traffic();
    int span, t, r;
    logic [hctc_pkg::TEMP_W-1:0] d;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) d = 16'h8000;
      else if (ph == 1) d = 16'h7FFF;
      else if ($urandom_range(0, 4) == 0) d = hctc_pkg::TEMP_W'($urandom);
      else d = hctc_pkg::TEMP_W'($urandom_range(3000, 8000));
      write_reg(hctc_pkg::CFG_TARGET, d);
      d = hctc_pkg::TEMP_W'($urandom);
      d[0] = (ph == 2) ? 1'b0 : ($urandom_range(0, 9) != 0);
      write_reg(hctc_pkg::CFG_ENABLE, d);
      d = hctc_pkg::TEMP_W'($urandom);
      write_reg(hctc_pkg::CFG_MODE, d);
      d = hctc_pkg::TEMP_W'($urandom);
      d[hctc_pkg::BAND_W-1:0] = (ph == 0) ? 12'hFFF : (ph == 1) ? 12'd0 :
                                hctc_pkg::BAND_W'($urandom_range(0, 600));
      write_reg(hctc_pkg::CFG_INNER, d);
      d = hctc_pkg::TEMP_W'($urandom);
      d[hctc_pkg::BAND_W-1:0] = (ph == 0) ? 12'hFFF : (ph == 1) ? 12'd0 :
                                hctc_pkg::BAND_W'($urandom_range(0, 1500));
      write_reg(hctc_pkg::CFG_OUTER, d);
      if (ph == 3) d = 16'd0;
      else if (ph == 5) d = 16'hFFFF;
      else d = hctc_pkg::TEMP_W'($urandom_range(1, 12));
      write_reg(hctc_pkg::CFG_STALE, d);
      if (ph == 4) begin
        write_reg(CFG_SPARE6, hctc_pkg::TEMP_W'($urandom));
        write_reg(CFG_SPARE7, hctc_pkg::TEMP_W'($urandom));
      end
      span = int'(inner_m) + int'(outer_m) + 200;
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 3) != 0) begin
            t = int'(target_m) + int'($urandom_range(0, 2 * span)) - span;
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
          end else begin
            t = int'(rnd_temp());
          end
          send_item(hctc_pkg::OP_UPDATE, rnd_idx(), hctc_pkg::TEMP_W'(t));
        end else if (r < 65) begin
          send_item(hctc_pkg::OP_TICK, rnd_idx(), rnd_temp());
        end else if (r < 95) begin
          send_item(hctc_pkg::OP_EVAL, rnd_idx(), rnd_temp());
        end else begin
          send_item(OP_SPARE, rnd_idx(), rnd_temp());
        end
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_heating_cycle();
    test_cooling_cycle();
    test_direction_memory();
    test_comfort_modes();
    test_extremes_and_disable();
    test_stale_boundary();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("heat_cool_thermostat_controller verification clean");
    end else begin
      $display("heat_cool_thermostat_controller verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/hctc_pkg.sv
design/hctc_ctrl.sv
design/hctc_datapath.sv
design/heat_cool_thermostat_controller.sv
design/hctc_checker.sv
tb/heat_cool_thermostat_controller_tb.sv
